FILE: src/itrd_pkg.sv
// Shared types, constants and helper functions for the integer to radix digits block.
package itrd_pkg;

    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 6;
    localparam int RADIX_W   = 5;
    localparam int SYM_W     = 64;
    localparam int DIGIT_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0]  MINUS_CHAR = 8'h2D;
    localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX        = 2'd0,
        CFG_SYMBOLS_LOW  = 2'd1,
        CFG_SYMBOLS_HIGH = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_ALIGN,
        S_SIGN,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic align;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_done;
        logic neg;
        logic last_digit;
        logic out_free;
    } t_dp_status;

    function automatic logic [CHAR_W-1:0] symbol_of(
        input logic [SYM_W-1:0]   sym_low,
        input logic [SYM_W-1:0]   sym_high,
        input logic [DIGIT_W-1:0] digit
    );
        logic [SYM_W-1:0] word;
        word = digit[DIGIT_W-1] ? sym_high : sym_low;
        return word[digit[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

FILE: src/itrd_in_if.sv
// Request channel carrying one integer word and its signedness flag.
interface itrd_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  is_signed;

    modport source (output valid, output value, output is_signed, input ready);
    modport sink   (input valid, input value, input is_signed, output ready);
endinterface

FILE: src/itrd_out_if.sv
// Result channel carrying one output character with its last marker and running count.
interface itrd_out_if
    import itrd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output character, output last, output count, input ready);
    modport sink   (input valid, input character, input last, input count, output ready);
endinterface

FILE: src/itrd_ctrl.sv
// Controller state machine sequencing load, conversion, alignment and character emission.
module itrd_ctrl
    import itrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (i_status.conv_done) begin
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                n_state = i_status.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (i_status.out_free) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_status.out_free && i_status.last_digit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
            end
            S_ALIGN: begin
                o_cmd.align = 1'b1;
            end
            S_SIGN: begin
                o_cmd.emit_sign = i_status.out_free;
            end
            S_DIGIT: begin
                o_cmd.emit_digit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/itrd_dp.sv
// Datapath with the digit cell row, magnitude shifter, counters and output register.
module itrd_dp
    import itrd_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_is_signed,
    input  logic [RADIX_W-1:0]    i_radix,
    input  logic [SYM_W-1:0]      i_symbols_low,
    input  logic [SYM_W-1:0]      i_symbols_high,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [CHAR_W-1:0]     o_out_character,
    output logic                  o_out_last,
    output logic [COUNT_W-1:0]    o_out_count
);

    localparam int CNT_W  = $clog2(VALUE_BITS);
    localparam int NDIG_W = $clog2(VALUE_BITS + 1);
    localparam int ROW_W  = DIGIT_W * VALUE_BITS;

    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_neg;
    logic [ROW_W-1:0]      r_row;
    logic [NDIG_W-1:0]     r_ndig;
    logic [NDIG_W-1:0]     r_left;
    logic [CNT_W-1:0]      r_bit_cnt;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_character;
    logic                  r_out_last;
    logic [COUNT_W-1:0]    r_out_count;

    logic [RADIX_W-1:0]    radix_eff;
    logic                  neg_in;
    logic [VALUE_BITS-1:0] mag_in;
    logic [VALUE_BITS-1:0] gen;
    logic [VALUE_BITS-1:0] prop;
    logic [VALUE_BITS:0]   csum;
    logic [VALUE_BITS:0]   carry;
    logic [ROW_W-1:0]      row_step;
    logic [NDIG_W-1:0]     shamt;
    logic [COUNT_W-1:0]    count_next;
    logic                  out_free;

    always_comb begin
        if (i_radix < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = i_radix;
        end
    end

    assign neg_in = i_is_signed & i_value[VALUE_BITS-1];
    assign mag_in = neg_in ? (~i_value + VALUE_BITS'(1)) : i_value;

    // Each cell doubles its digit and adds the carry from below; the carries
    // ripple like an adder, so they are formed with one wide addition.
    always_comb begin
        for (int i = 0; i < VALUE_BITS; i++) begin
            gen[i]  = {r_row[i*DIGIT_W +: DIGIT_W], 1'b0} >= radix_eff;
            prop[i] = ({r_row[i*DIGIT_W +: DIGIT_W], 1'b0} + RADIX_W'(1)) == radix_eff;
        end
        csum  = {1'b0, gen | prop} + {1'b0, gen} + (VALUE_BITS+1)'(r_mag[VALUE_BITS-1]);
        carry = csum ^ {1'b0, gen | prop} ^ {1'b0, gen};
        for (int i = 0; i < VALUE_BITS; i++) begin
            row_step[i*DIGIT_W +: DIGIT_W] = DIGIT_W'({r_row[i*DIGIT_W +: DIGIT_W], carry[i]}
                - (carry[i+1] ? radix_eff : RADIX_W'(0)));
        end
    end

    assign shamt      = NDIG_W'(VALUE_BITS) - r_ndig;
    assign count_next = r_count + COUNT_W'(1);
    assign out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag     <= mag_in;
            r_neg     <= neg_in;
            r_row     <= '0;
            r_ndig    <= NDIG_W'(1);
            r_bit_cnt <= CNT_W'(VALUE_BITS - 1);
            r_count   <= '0;
        end else if (i_cmd.step) begin
            r_mag     <= r_mag << 1;
            r_row     <= row_step;
            r_ndig    <= r_ndig + NDIG_W'(carry[r_ndig]);
            r_bit_cnt <= r_bit_cnt - CNT_W'(1);
        end else if (i_cmd.align) begin
            r_row  <= r_row << (shamt * DIGIT_W);
            r_left <= r_ndig;
        end else if (i_cmd.emit_sign) begin
            r_count <= count_next;
        end else if (i_cmd.emit_digit) begin
            r_row   <= r_row << DIGIT_W;
            r_left  <= r_left - NDIG_W'(1);
            r_count <= count_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_character <= MINUS_CHAR;
            r_out_last      <= 1'b0;
            r_out_count     <= count_next;
        end else if (i_cmd.emit_digit) begin
            r_out_character <= symbol_of(i_symbols_low, i_symbols_high,
                                         r_row[ROW_W-1 -: DIGIT_W]);
            r_out_last      <= (r_left == NDIG_W'(1));
            r_out_count     <= count_next;
        end
    end

    assign o_status.conv_done  = (r_bit_cnt == '0);
    assign o_status.neg        = r_neg;
    assign o_status.last_digit = (r_left == NDIG_W'(1));
    assign o_status.out_free   = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_out_character = r_out_character;
    assign o_out_last      = r_out_last;
    assign o_out_count     = r_out_count;

endmodule

FILE: src/integer_to_radix_digits_core.sv
// Top level of the integer to radix digits converter with its configuration registers.
// Usage: a request on i_in carries a VALUE_BITS-wide word and a signed flag. The block
// answers with one result on o_out per character, most significant digit first, a
// minus character leading for a negative signed word. Each result carries the
// character byte, a last marker and the running character count of the number.
// The user must set the radix and the sixteen digit symbols through the write port
// (i_cfg_wr_en, i_cfg_index, i_cfg_data) while the block is idle; it is not enforced.
// A request is taken, then the magnitude is shifted bit by bit, all VALUE_BITS bits,
// into a row of digit cells; an alignment step follows, and then one character
// leaves per cycle while the receiver is ready. One request is handled at a time.
// Results go through an output register, so the last character can wait there
// while the next request is taken. When the receiver stalls, emission pauses and
// nothing is lost. Reset returns the controller to idle, empties the output
// register, sets the radix to ten and clears the symbol table.
module integer_to_radix_digits_core
    import itrd_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    itrd_in_if.sink              i_in,
    itrd_out_if.source           o_out,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SYM_W-1:0]     i_cfg_data
);

    logic [RADIX_W-1:0] r_radix;
    logic [SYM_W-1:0]   r_symbols_low;
    logic [SYM_W-1:0]   r_symbols_high;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix        <= RADIX_W'(10);
            r_symbols_low  <= '0;
            r_symbols_high <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RADIX:        r_radix        <= i_cfg_data[RADIX_W-1:0];
                CFG_SYMBOLS_LOW:  r_symbols_low  <= i_cfg_data;
                CFG_SYMBOLS_HIGH: r_symbols_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    itrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (dp_cmd),
        .i_status   (dp_status)
    );

    itrd_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_value         (i_in.value),
        .i_is_signed     (i_in.is_signed),
        .i_radix         (r_radix),
        .i_symbols_low   (r_symbols_low),
        .i_symbols_high  (r_symbols_high),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_out_character (o_out.character),
        .o_out_last      (o_out.last),
        .o_out_count     (o_out.count)
    );

`ifndef ASSERT_OFF
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while a conversion was starting");

    a_no_request_mid_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> !i_in.ready)
        else $error("ready raised before the last character was produced");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) ##1 o_out.valid |->
        o_out.count == COUNT_W'($past(o_out.count) + COUNT_W'(1)))
        else $error("character count did not advance by one");
`endif

endmodule
